[rtl/adcdmx_pkg.sv]
// shared types, codes and constants of the adc event word demux
package adcdmx_pkg;

    // word type codes in bits 26:24
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd2;
    localparam logic [2:0] KIND_EOB    = 3'd4;

    // configuration register indexes
    localparam logic REG_NUM_CHANNELS = 1'b0;
    localparam logic REG_ADC_BITS     = 1'b1;

    localparam int CFG_DATA_W       = 6;
    localparam int DEF_MAX_CHANNELS = 32;

    localparam logic [5:0] NUM_CHANNELS_RST = 6'd32;
    localparam logic [3:0] ADC_BITS_RST     = 4'd12;
    localparam logic [3:0] ADC_BITS_FULL    = 4'd12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVENT,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic clear_valid;
        logic store;
        logic start_scan;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic is_header;
        logic is_data;
        logic is_eob;
        logic any_valid;
        logic slot_free;
    } t_status;

endpackage

[rtl/adcdmx_ctrl.sv]
// controller: event state and emission sequencing
module adcdmx_ctrl
    import adcdmx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state != S_SCAN);
        accept     = i_in_valid && o_in_ready;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_status.is_header) begin
                    o_cmd.clear_valid = 1'b1;
                    n_state           = S_EVENT;
                end
            end
            S_EVENT: begin
                if (accept && i_status.is_data) begin
                    o_cmd.store = 1'b1;
                end else if (accept && i_status.is_eob) begin
                    o_cmd.start_scan = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.any_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/adcdmx_dp.sv]
// datapath: config registers, channel table, scan index and output register
module adcdmx_dp
    import adcdmx_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [31:0]           i_data_word,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [4:0]            o_channel,
    output logic [11:0]           o_value,
    output logic [23:0]           o_event_count,
    output logic                  o_last
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [5:0]              r_num_ch;
    logic [3:0]              r_adc_bits;
    logic [MAX_CHANNELS-1:0] r_valid;
    logic [11:0]             r_value [MAX_CHANNELS];
    logic [IDX_W-1:0]        r_idx;
    logic [23:0]             r_evc;
    logic                    r_out_valid;
    logic [4:0]              r_channel;
    logic [11:0]             r_out_value;
    logic [23:0]             r_out_evc;
    logic                    r_last;

    logic [2:0]              kind;
    logic [4:0]              ch;
    logic [11:0]             val;
    logic [IDX_W-1:0]        wr_idx;
    logic                    ch_ok;
    logic                    val_ok;
    logic                    store_ok;
    logic                    cur_valid;
    logic [MAX_CHANNELS-1:0] rest;
    logic                    load;

    assign kind   = i_data_word[26:24];
    assign ch     = i_data_word[20:16];
    assign val    = i_data_word[11:0];
    assign wr_idx = ch[IDX_W-1:0];

    assign ch_ok  = ({1'b0, ch} < r_num_ch) && (32'(ch) < MAX_CHANNELS);
    assign val_ok = (r_adc_bits >= ADC_BITS_FULL) || ((val >> r_adc_bits) == 12'd0);
    assign store_ok = i_cmd.store && ch_ok && !i_data_word[12] && val_ok
                      && !r_valid[wr_idx];

    assign cur_valid = (32'(r_idx) < MAX_CHANNELS) && r_valid[r_idx];
    assign load      = i_cmd.step && cur_valid;

    always_comb begin
        rest        = r_valid;
        rest[r_idx] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch   <= NUM_CHANNELS_RST;
            r_adc_bits <= ADC_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_NUM_CHANNELS: r_num_ch   <= i_cfg_data[5:0];
                REG_ADC_BITS:     r_adc_bits <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_valid) begin
            r_valid <= '0;
        end else if (store_ok) begin
            r_valid[wr_idx] <= 1'b1;
        end else if (load) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_ok) begin
            r_value[wr_idx] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_idx <= '0;
            r_evc <= i_data_word[23:0];
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_channel   <= 5'(r_idx);
            r_out_value <= r_value[r_idx];
            r_out_evc   <= r_evc;
            r_last      <= (rest == '0);
        end
    end

    assign o_status.is_header = (kind == KIND_HEADER);
    assign o_status.is_data   = (kind == KIND_DATA);
    assign o_status.is_eob    = (kind == KIND_EOB);
    assign o_status.any_valid = |r_valid;
    assign o_status.slot_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_channel     = r_channel;
    assign o_value       = r_out_value;
    assign o_event_count = r_out_evc;
    assign o_last        = r_last;

endmodule

[rtl/adc_event_word_demux_unit.sv]
// top level of the adc event word demux
// Decodes a stream of 32-bit adc readout words (type in bits 26:24: header,
// data, end of block). Header, data and ignored words are taken one per
// cycle while no emission walk runs. An end-of-block word closes the event
// and the block then walks the channel table one entry per cycle while the
// output register is free, MAX_CHANNELS entries at most, emitting each stored
// channel/value pair in ascending order with the event counter; input ready
// stays low for that walk. The output register lets the next item in while
// the final pair still waits to be taken. Configuration should be written
// through a plain write port only while the block is idle; the block itself
// does not enforce this.
module adc_event_word_demux_unit
    import adcdmx_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // readout word items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_data_word,
    // channel/value items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [4:0]            o_channel,
    output logic [11:0]           o_value,
    output logic [23:0]           o_event_count,
    output logic                  o_last
);

    // command and status between controller and datapath
    t_cmd    cmd;
    t_status status;

    // controller tracks whether an event is open and runs the emission walk
    adcdmx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath holds the valid marks, the value table and the output register
    adcdmx_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_data_word   (i_data_word),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_channel     (o_channel),
        .o_value       (o_value),
        .o_event_count (o_event_count),
        .o_last        (o_last)
    );

endmodule

[rtl/adcdmx_checker.sv]
// port-level checker for the adc event word demux, bound to the top level
module adcdmx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  o_channel,
    input logic [11:0] o_value,
    input logic [23:0] o_event_count,
    input logic        o_last
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_channel)
            && $stable(o_value) && $stable(o_event_count) && $stable(o_last))
        else $error("stalled result item changed");

    // while a non-final pair is pending the emission walk still blocks input
    a_busy_until_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input taken before the final pair of an event");

    // reset leaves no result item
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item present after reset");

endmodule

bind adc_event_word_demux_unit adcdmx_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_channel     (o_channel),
    .o_value       (o_value),
    .o_event_count (o_event_count),
    .o_last        (o_last)
);
